// File: rtl/core/dvlr_pkg.sv
package dvlr_pkg;

    localparam int NUM_PADS_DEF   = 8;
    localparam int NUM_RANGES_DEF = 4;

    localparam int CMD_W    = 2;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int PIDX_W   = 3;
    localparam int SEL_W    = 5;
    localparam int VAL_W    = 16;
    localparam int HOLD_W   = 16;
    localparam int TIME_W   = 32;
    localparam int PROD_W   = 2 * VEL_W;
    localparam int REM_W    = VEL_W + 1;
    localparam int DCNT_W   = $clog2(PROD_W);

    localparam logic [CMD_W-1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd3;

    localparam logic [SEL_W-1:0] FS_TRIG      = 5'd0;
    localparam logic [SEL_W-1:0] FS_MINVEL    = 5'd1;
    localparam logic [SEL_W-1:0] FS_EN        = 5'd2;
    localparam logic [SEL_W-1:0] FS_HOLD      = 5'd3;
    localparam logic [SEL_W-1:0] FS_RNG_BASE  = 5'd4;

    localparam logic [1:0] RK_UPPER = 2'd0;
    localparam logic [1:0] RK_NOTE  = 2'd1;
    localparam logic [1:0] RK_MAX   = 2'd2;
    localparam logic [1:0] RK_HOLD  = 2'd3;

    typedef struct packed {
        logic [NOTE_W-1:0] trig;
        logic [VEL_W-1:0]  minvel;
        logic              en;
        logic [HOLD_W-1:0] hold;
        logic [TIME_W-1:0] last_time;
        logic [NOTE_W-1:0] last_note;
    } pad_rec_t;

    typedef struct packed {
        logic [VEL_W-1:0]  upper;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  maxv;
        logic [HOLD_W-1:0] hold;
    } rng_rec_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic pad_rd;
        logic pad_next;
        logic pad_latch;
        logic set_repeat;
        logic rng_init;
        logic rng_rd;
        logic rng_next;
        logic rng_latch;
        logic div_init;
        logic div_step;
        logic set_range;
        logic pad_wb;
        logic tw_rd;
        logic tw_wr;
        logic emit_first;
        logic emit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic clr_done;
        logic pad_match;
        logic pad_en;
        logic in_window;
        logic pad_last;
        logic rng_hit;
        logic rng_last;
        logic div_last;
        logic wr_valid;
        logic out_free;
    } ctrl_sts_t;

endpackage

// File: rtl/core/dvlr_ram.sv
module dvlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/dvlr_ctrl.sv
module dvlr_ctrl import dvlr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_RNG_RD, S_RNG_CHK,
        S_MUL, S_DIV, S_FIN, S_WB, S_EMIT1, S_EMIT2, S_TW_RD, S_TW_WR
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (sts.in_cmd)
                        CMD_NOTE_ON:  state_next = S_SCAN_RD;
                        CMD_NOTE_OFF: state_next = S_EMIT2;
                        CMD_WRITE:    state_next = S_TW_RD;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                cmd.pad_rd = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.pad_match)
                begin
                    cmd.pad_latch = 1'b1;
                    if (sts.pad_en && sts.in_window)
                    begin
                        cmd.set_repeat = 1'b1;
                        state_next     = S_WB;
                    end
                    else if (sts.pad_en)
                    begin
                        cmd.rng_init = 1'b1;
                        state_next   = S_RNG_RD;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
                else if (sts.pad_last)
                begin
                    state_next = S_EMIT1;
                end
                else
                begin
                    cmd.pad_next = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_RNG_RD:
            begin
                cmd.rng_rd = 1'b1;
                state_next = S_RNG_CHK;
            end
            S_RNG_CHK:
            begin
                if (sts.rng_hit)
                begin
                    cmd.rng_latch = 1'b1;
                    state_next    = S_MUL;
                end
                else if (sts.rng_last)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    cmd.rng_next = 1'b1;
                    state_next   = S_RNG_RD;
                end
            end
            S_MUL:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.set_range = 1'b1;
                state_next    = S_WB;
            end
            S_WB:
            begin
                cmd.pad_wb = 1'b1;
                state_next = S_EMIT1;
            end
            S_EMIT1:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = S_EMIT2;
                end
            end
            S_EMIT2:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_TW_RD:
            begin
                if (sts.wr_valid)
                begin
                    cmd.tw_rd  = 1'b1;
                    state_next = S_TW_WR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_TW_WR:
            begin
                cmd.tw_wr  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_first || cmd.emit_final) |-> sts.out_free)
        else $error("result loaded while output register busy");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (state_reg != S_CLEAR))
        else $error("clear pass re-entered");

    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(cmd.pad_wb || cmd.tw_wr || cmd.div_step))
        else $error("ready while item in flight");

endmodule

// File: rtl/core/dvlr_dp.sv
module dvlr_dp import dvlr_pkg::*; #(
    parameter int NUM_PADS   = NUM_PADS_DEF,
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [NOTE_W-1:0] note,
    input  logic [VEL_W-1:0]  velocity,
    input  logic [PIDX_W-1:0] pad_index,
    input  logic [SEL_W-1:0]  field_select,
    input  logic [VAL_W-1:0]  write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NOTE_W-1:0] out_note,
    output logic [VEL_W-1:0]  out_velocity,
    output logic              last,
    input  ctrl_cmd_t         ctl,
    output ctrl_sts_t         sts
);

    localparam int RNG_N  = NUM_PADS * NUM_RANGES;
    localparam int PAD_AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int RNG_AW = (RNG_N > 1) ? $clog2(RNG_N) : 1;
    localparam int RI_W   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;

    logic [RNG_AW-1:0] clr_cnt_reg;
    logic [TIME_W-1:0] now_reg;
    logic [NOTE_W-1:0] n_reg;
    logic [VEL_W-1:0]  v_reg;
    logic [PIDX_W-1:0] wpad_reg;
    logic [SEL_W-1:0]  wsel_reg;
    logic [VAL_W-1:0]  wval_reg;
    logic [PAD_AW-1:0] p_reg;
    logic [RI_W-1:0]   r_reg;
    logic [VEL_W-1:0]  lower_reg;
    pad_rec_t          pad_rec_reg;
    logic [HOLD_W-1:0] rhold_reg;
    logic [NOTE_W-1:0] rnote_reg;
    logic [VEL_W-1:0]  div_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [REM_W+PROD_W-1:0] acc_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              out_valid_reg;
    logic [NOTE_W-1:0] out_note_reg;
    logic [VEL_W-1:0]  out_vel_reg;
    logic              out_last_reg;

    pad_rec_t          pad_rd_data, pad_wdata;
    rng_rec_t          rng_rd_data, rng_wdata;
    logic              pad_we, rng_we;
    logic [PAD_AW-1:0] pad_waddr, pad_raddr, wpad_addr;
    logic [RNG_AW-1:0] rng_waddr, rng_raddr, scan_entry, wr_entry;
    logic [SEL_W-1:0]  sel_off;
    logic [2:0]        wr_rng;
    logic              wr_is_pad;
    logic [TIME_W-1:0] elapsed;
    logic [REM_W+PROD_W-1:0] acc_sh;
    logic [REM_W-1:0]  acc_hi;
    logic              clr_pad;

    assign wpad_addr  = PAD_AW'(wpad_reg);
    assign sel_off    = wsel_reg - FS_RNG_BASE;
    assign wr_rng     = sel_off[4:2];
    assign wr_is_pad  = (wsel_reg < FS_RNG_BASE);
    assign scan_entry = RNG_AW'(p_reg) * RNG_AW'(NUM_RANGES) + RNG_AW'(r_reg);
    assign wr_entry   = RNG_AW'(wpad_reg) * RNG_AW'(NUM_RANGES) + RNG_AW'(wr_rng);
    assign clr_pad    = (32'(clr_cnt_reg) < NUM_PADS);
    assign elapsed    = now_reg - pad_rd_data.last_time;

    always_comb
    begin
        pad_raddr = ctl.tw_rd ? wpad_addr : p_reg;
        rng_raddr = ctl.tw_rd ? wr_entry : scan_entry;
        pad_we    = 1'b0;
        pad_waddr = p_reg;
        pad_wdata = pad_rec_reg;
        rng_we    = 1'b0;
        rng_waddr = wr_entry;
        rng_wdata = rng_rd_data;
        if (ctl.clr_step)
        begin
            pad_we    = clr_pad;
            pad_waddr = clr_cnt_reg[PAD_AW-1:0];
            pad_wdata = '0;
            rng_we    = 1'b1;
            rng_waddr = clr_cnt_reg;
            rng_wdata = '0;
        end
        else if (ctl.pad_wb)
        begin
            pad_we              = 1'b1;
            pad_wdata.last_time = now_reg;
            pad_wdata.last_note = n_reg;
        end
        else if (ctl.tw_wr)
        begin
            pad_waddr = wpad_addr;
            pad_wdata = pad_rd_data;
            if (wr_is_pad)
            begin
                pad_we = 1'b1;
                case (wsel_reg)
                    FS_TRIG:   pad_wdata.trig   = wval_reg[NOTE_W-1:0];
                    FS_MINVEL: pad_wdata.minvel = wval_reg[VEL_W-1:0];
                    FS_EN:     pad_wdata.en     = wval_reg[0];
                    default:   pad_wdata.hold   = wval_reg[HOLD_W-1:0];
                endcase
            end
            else
            begin
                rng_we = 1'b1;
                case (sel_off[1:0])
                    RK_UPPER: rng_wdata.upper = wval_reg[VEL_W-1:0];
                    RK_NOTE:  rng_wdata.note  = wval_reg[NOTE_W-1:0];
                    RK_MAX:   rng_wdata.maxv  = wval_reg[VEL_W-1:0];
                    default:  rng_wdata.hold  = wval_reg[HOLD_W-1:0];
                endcase
            end
        end
    end

    dvlr_ram #(.WIDTH($bits(pad_rec_t)), .DEPTH(NUM_PADS), .AW(PAD_AW)) u_pad_ram (
        .clk   (clk),
        .we    (pad_we),
        .waddr (pad_waddr),
        .wdata (pad_wdata),
        .raddr (pad_raddr),
        .rdata (pad_rd_data)
    );

    dvlr_ram #(.WIDTH($bits(rng_rec_t)), .DEPTH(RNG_N), .AW(RNG_AW)) u_rng_ram (
        .clk   (clk),
        .we    (rng_we),
        .waddr (rng_waddr),
        .wdata (rng_wdata),
        .raddr (rng_raddr),
        .rdata (rng_rd_data)
    );

    // restoring division, one quotient bit per step
    always_comb
    begin
        acc_sh = {acc_reg[REM_W+PROD_W-2:0], 1'b0};
        acc_hi = acc_sh[REM_W+PROD_W-1:PROD_W];
        if (acc_hi >= {1'b0, div_reg})
        begin
            acc_sh[REM_W+PROD_W-1:PROD_W] = acc_hi - {1'b0, div_reg};
            acc_sh[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctl.load && (cmd == CMD_TICK))
            begin
                now_reg <= now_reg + 1'b1;
            end
            if (ctl.emit_first || ctl.emit_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            n_reg    <= note;
            v_reg    <= velocity;
            wpad_reg <= pad_index;
            wsel_reg <= field_select;
            wval_reg <= write_value;
            p_reg    <= '0;
        end
        if (ctl.pad_next)
        begin
            p_reg <= p_reg + 1'b1;
        end
        if (ctl.pad_latch)
        begin
            pad_rec_reg <= pad_rd_data;
        end
        if (ctl.set_repeat)
        begin
            n_reg <= pad_rd_data.last_note;
        end
        if (ctl.rng_init)
        begin
            r_reg     <= '0;
            lower_reg <= pad_rd_data.minvel;
        end
        if (ctl.rng_next)
        begin
            r_reg     <= r_reg + 1'b1;
            lower_reg <= rng_rd_data.upper;
        end
        if (ctl.rng_latch)
        begin
            prod_reg  <= {{VEL_W{1'b0}}, rng_rd_data.maxv} * {{VEL_W{1'b0}}, v_reg};
            div_reg   <= rng_rd_data.upper;
            rnote_reg <= rng_rd_data.note;
            rhold_reg <= rng_rd_data.hold;
        end
        if (ctl.div_init)
        begin
            acc_reg  <= {{REM_W{1'b0}}, prod_reg};
            dcnt_reg <= '0;
        end
        if (ctl.div_step)
        begin
            acc_reg  <= acc_sh;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (ctl.set_range)
        begin
            n_reg            <= rnote_reg;
            v_reg            <= acc_reg[VEL_W-1:0];
            pad_rec_reg.hold <= rhold_reg;
        end
        if (ctl.emit_first)
        begin
            out_note_reg <= n_reg;
            out_vel_reg  <= v_reg;
            out_last_reg <= 1'b0;
        end
        if (ctl.emit_final)
        begin
            out_note_reg <= n_reg;
            out_vel_reg  <= '0;
            out_last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        sts.in_cmd    = cmd;
        sts.clr_done  = (clr_cnt_reg == RNG_AW'(RNG_N - 1));
        sts.pad_match = (pad_rd_data.trig == n_reg);
        sts.pad_en    = pad_rd_data.en;
        sts.in_window = (elapsed < {{(TIME_W-HOLD_W){1'b0}}, pad_rd_data.hold});
        sts.pad_last  = (p_reg == PAD_AW'(NUM_PADS - 1));
        sts.rng_hit   = (v_reg > lower_reg) && (v_reg <= rng_rd_data.upper);
        sts.rng_last  = (r_reg == RI_W'(NUM_RANGES - 1));
        sts.div_last  = (dcnt_reg == DCNT_W'(PROD_W - 1));
        sts.wr_valid  = ({4'b0, wpad_reg} < 7'(NUM_PADS))
                        && (wr_is_pad || ({1'b0, wr_rng} < 4'(NUM_RANGES)));
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_note     = out_note_reg;
    assign out_velocity = out_vel_reg;
    assign last         = out_last_reg;

    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ctl.emit_first || ctl.emit_final))
        else $error("output valid without a result load");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_step |-> (div_reg != '0))
        else $error("division by zero upper bound");

    a_hit_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rng_latch |-> (sts.rng_hit && (p_reg <= PAD_AW'(NUM_PADS - 1))))
        else $error("range latched without a hit");

endmodule

// File: rtl/core/drum_velocity_layer_remapper_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    cmd, note, velocity, pad_index,
//                                             field_select, write_value
// result    out        out_valid / out_ready  out_note, out_velocity, last
//
// One item at a time. A tick is done once accepted. A note-off makes one result
// transfer. A table write reads the target record, then writes it back (an
// out-of-range target is dropped). A note-on scans pads up to the first match,
// tries velocity ranges, then runs the multiply, the 14-step restoring divider
// and the result load, a writeback, then 2 result transfers.
// After reset a clearing pass zeroes the tables; in_ready stays low during it.
// A stalled output only holds the result transfers.
module drum_velocity_layer_remapper_top import dvlr_pkg::*; #(
    parameter int NUM_PADS   = NUM_PADS_DEF,
    parameter int NUM_RANGES = NUM_RANGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [NOTE_W-1:0] note,
    input  logic [VEL_W-1:0]  velocity,
    input  logic [PIDX_W-1:0] pad_index,
    input  logic [SEL_W-1:0]  field_select,
    input  logic [VAL_W-1:0]  write_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [NOTE_W-1:0] out_note,
    output logic [VEL_W-1:0]  out_velocity,
    output logic              last
);

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    dvlr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (ctl)
    );

    dvlr_dp #(.NUM_PADS(NUM_PADS), .NUM_RANGES(NUM_RANGES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .note         (note),
        .velocity     (velocity),
        .pad_index    (pad_index),
        .field_select (field_select),
        .write_value  (write_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_note     (out_note),
        .out_velocity (out_velocity),
        .last         (last),
        .ctl          (ctl),
        .sts          (sts)
    );

endmodule
